FILE: sv/svr_pkg.sv
package svr_pkg;

  localparam int VelocityFracBits = 16;
  localparam int EaseFracBits = 16;
  localparam int TimeBits = 24;
  localparam int DurBits = 24;
  localparam int TickBits = 16;
  localparam int VelBits = 32;
  localparam logic [DurBits-1:0] MinDurationReset = 24'd1000;
  localparam int DefaultDuration = 500000;

  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_ACCEL = 3'd1,
    OP_DECEL = 3'd2,
    OP_ESTOP = 3'd3,
    OP_RESET = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    M_IDLE   = 2'd0,
    M_ACCEL  = 2'd1,
    M_CRUISE = 2'd2,
    M_DECEL  = 2'd3
  } mode_t;

  // datapath commands issued by the controller
  typedef struct packed {
    logic load;      // capture input transaction and decode
    logic div_start; // begin the progress divide
    logic div_step;  // one quotient bit
    logic mul_t2;    // t2 = t*t
    logic mul_t3;    // t3 = t2*t
    logic mul_in;    // inner polynomial
    logic mul_ez;    // ease = t3*inner
    logic mul_dv;    // delta = |diff|*ease
    logic finish;    // commit state and result
  } svr_cmd_t;

  typedef struct packed {
    logic ramp_tick; // decoded transaction is a tick in accel or decel
    logic div_done;
  } svr_sts_t;

endpackage

FILE: sv/svr_ctrl.sv
module svr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_fire,
  input  logic                out_busy,
  input  svr_pkg::svr_sts_t   sts,
  output svr_pkg::svr_cmd_t   cmd,
  output logic                idle
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DEC  = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_T2   = 9'b000001000,
    S_T3   = 9'b000010000,
    S_IN   = 9'b000100000,
    S_EZ   = 9'b001000000,
    S_DV   = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t state, state_next;

  // sequencing of one transaction
  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.ramp_tick) begin
          cmd.div_start = 1'b1;
          state_next = S_DIV;
        end else begin
          state_next = S_FIN;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = S_T2;
      end
      S_T2: begin
        cmd.mul_t2 = 1'b1;
        state_next = S_T3;
      end
      S_T3: begin
        cmd.mul_t3 = 1'b1;
        state_next = S_IN;
      end
      S_IN: begin
        cmd.mul_in = 1'b1;
        state_next = S_EZ;
      end
      S_EZ: begin
        cmd.mul_ez = 1'b1;
        state_next = S_DV;
      end
      S_DV: begin
        cmd.mul_dv = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (!out_busy) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign idle = (state == S_IDLE);

  assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  assert property (@(posedge clk) disable iff (rst) cmd.finish |=> state == S_IDLE)
    else $error("finish did not return to idle");
  assert property (@(posedge clk) disable iff (rst) cmd.load |=> state == S_DEC)
    else $error("load did not enter decode");

endmodule

FILE: sv/svr_datapath.sv
module svr_datapath #(
  parameter int VelocityFracBits = svr_pkg::VelocityFracBits,
  parameter int EaseFracBits = svr_pkg::EaseFracBits,
  parameter int TimeBits = svr_pkg::TimeBits
) (
  input  logic                            clk,
  input  logic                            rst,
  input  svr_pkg::svr_cmd_t               cmd,
  output svr_pkg::svr_sts_t               sts,
  input  logic [svr_pkg::DurBits-1:0]     min_duration_us,
  input  logic [2:0]                      opcode,
  input  logic signed [31:0]              target_velocity,
  input  logic [svr_pkg::DurBits-1:0]     ramp_duration_us,
  input  logic [svr_pkg::TickBits-1:0]    tick_us,
  output logic signed [31:0]              res_velocity,
  output logic [1:0]                      res_mode,
  output logic                            res_changed,
  output logic [1:0]                      res_prev,
  output logic                            res_latch
);

  localparam int EW = EaseFracBits + 2;          // ease/t width, holds 1.0
  localparam int DW = TimeBits + EaseFracBits;   // dividend width
  localparam int CW = $clog2(DW + 1);
  localparam logic [EW-1:0] EaseOne = EW'(1) << EaseFracBits;
  localparam logic [TimeBits-1:0] TimeMax = '1;
  localparam logic [TimeBits-1:0] DefDur =
    (svr_pkg::DefaultDuration > (2**TimeBits - 1)) ? TimeMax :
    TimeBits'(svr_pkg::DefaultDuration);
  localparam logic [63:0] ZeroLim = 64'(1) << VelocityFracBits;

  // architectural state
  logic signed [31:0] cur_vel, tgt_vel, origin_vel;
  logic [TimeBits-1:0] accel_dur, decel_dur, elapsed;
  svr_pkg::mode_t mode;
  logic latch;

  // captured transaction
  logic [2:0] op;
  logic signed [31:0] vin;
  logic [svr_pkg::DurBits-1:0] dur_in;
  logic [svr_pkg::TickBits-1:0] tick;

  // working registers
  logic [TimeBits-1:0] el_new, total;
  logic [DW-1:0] rem_q;    // dividend shifts out, quotient shifts in
  logic [TimeBits:0] rem;
  logic [CW-1:0] cnt;
  logic [EW-1:0] t, t2, t3, ez;
  logic [EW+3:0] inner;
  logic [32:0] mag;
  logic diff_neg;
  logic [32+EW-1:0] prod;

  function automatic logic near_zero(input logic signed [32:0] v);
    logic [32:0] m;
    m = v[32] ? 33'(-v) : v;
    return (64'(m) * 64'd1000000) < ZeroLim;
  endfunction

  // elapsed time update and divide inputs
  logic [TimeBits:0] el_sum;
  logic [TimeBits-1:0] el_min;
  assign el_sum = {1'b0, elapsed} + (TimeBits+1)'(tick);
  assign el_min = (el_new < total) ? el_new : total;

  logic [TimeBits:0] rem_sh, rem_sub;
  assign rem_sh = {rem[TimeBits-1:0], rem_q[DW-1]};
  assign rem_sub = rem_sh - {1'b0, total};

  assign sts = '{
    ramp_tick: (op == svr_pkg::OP_TICK) &&
               (mode == svr_pkg::M_ACCEL || mode == svr_pkg::M_DECEL),
    div_done:  (cnt == CW'(1))
  };

  // shared multiplier operands
  logic [32:0] ma;
  logic [EW+3:0] mb;
  logic [32+EW+3:0] mp;
  always_comb begin
    ma = '0;
    mb = '0;
    if (cmd.mul_t2) begin
      ma = 33'(t);  mb = (EW+4)'(t);
    end else if (cmd.mul_t3) begin
      ma = 33'(t2); mb = (EW+4)'(t);
    end else if (cmd.mul_ez) begin
      ma = 33'(t3); mb = inner;
    end else if (cmd.mul_dv) begin
      ma = mag;     mb = (EW+4)'(ez);
    end
  end
  assign mp = (32+EW+4)'(ma) * (32+EW+4)'(mb);

  // ease clamp and rounded interpolation
  logic [EW-1:0] ez_c;
  logic [32+EW+3:0] ezs;
  assign ezs = mp >> EaseFracBits;
  assign ez_c = (ezs > (32+EW+4)'(EaseOne)) ? EaseOne : ezs[EW-1:0];
  logic [32:0] q;
  assign q = 33'((prod + (32+EW)'(EaseOne >> 1)) >> EaseFracBits);
  logic signed [32:0] interp;
  assign interp = diff_neg ? (33'(origin_vel) - $signed(q)) : (33'(origin_vel) + $signed(q));

  logic signed [32:0] diff;
  assign diff = 33'(tgt_vel) - 33'(origin_vel);

  logic [TimeBits-1:0] dreq;
  always_comb begin
    logic [svr_pkg::DurBits-1:0] m;
    m = (dur_in > min_duration_us) ? dur_in : min_duration_us;
    if (TimeBits >= svr_pkg::DurBits) dreq = TimeBits'(m);
    else dreq = (m > svr_pkg::DurBits'(TimeMax)) ? TimeMax : TimeBits'(m);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_vel <= '0; tgt_vel <= '0; origin_vel <= '0;
      accel_dur <= DefDur; decel_dur <= DefDur; elapsed <= '0;
      mode <= svr_pkg::M_IDLE; latch <= 1'b0; cnt <= '0;
    end else begin
      if (cmd.load) begin
        op <= opcode; vin <= target_velocity; dur_in <= ramp_duration_us; tick <= tick_us;
      end
      if (cmd.div_start) begin
        el_new <= el_sum[TimeBits] ? TimeMax : el_sum[TimeBits-1:0];
        total <= (mode == svr_pkg::M_ACCEL) ? accel_dur : decel_dur;
        cnt <= CW'(DW + 1);
        rem <= '0;
        diff_neg <= diff[32];
        mag <= diff[32] ? 33'(-diff) : diff;
      end
      // restoring divide, one bit per cycle; first step loads the dividend
      if (cmd.div_step) begin
        if (cnt == CW'(DW + 1)) begin
          rem_q <= {el_min, {EaseFracBits{1'b0}}};
        end else begin
          if (!rem_sub[TimeBits]) begin
            rem <= rem_sub;
            rem_q <= {rem_q[DW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            rem_q <= {rem_q[DW-2:0], 1'b0};
          end
        end
        cnt <= cnt - CW'(1);
      end
      if (cmd.mul_t2) begin
        t2 <= EW'(mp >> EaseFracBits);
      end
      if (cmd.mul_t3) begin
        t3 <= EW'(mp >> EaseFracBits);
        inner <= '0;
      end
      if (cmd.mul_in) begin
        inner <= (EW+4)'(6) * (EW+4)'(t2) + (EW+4)'(10) * (EW+4)'(EaseOne)
                 - (EW+4)'(15) * (EW+4)'(t);
      end
      if (cmd.mul_ez) ez <= ez_c;
      if (cmd.mul_dv) prod <= (32+EW)'(mp);
      if (cmd.finish) begin
        res_prev <= mode;
        res_changed <= 1'b0;
        case (op)
          svr_pkg::OP_TICK: begin
            if (mode == svr_pkg::M_IDLE) begin
              cur_vel <= tgt_vel; res_velocity <= tgt_vel; res_mode <= mode;
            end else if (mode == svr_pkg::M_CRUISE) begin
              if (!near_zero(33'(cur_vel) - 33'(tgt_vel))) begin
                cur_vel <= tgt_vel; res_velocity <= tgt_vel;
              end else begin
                res_velocity <= cur_vel;
              end
              res_mode <= mode;
            end else begin
              elapsed <= el_new;
              if (total == '0 || el_new >= total) begin
                mode <= near_zero(33'(tgt_vel)) ? svr_pkg::M_IDLE : svr_pkg::M_CRUISE;
                res_mode <= near_zero(33'(tgt_vel)) ? svr_pkg::M_IDLE : svr_pkg::M_CRUISE;
                cur_vel <= tgt_vel; res_velocity <= tgt_vel;
              end else begin
                cur_vel <= interp[31:0]; res_velocity <= interp[31:0];
                res_mode <= mode;
              end
            end
          end
          svr_pkg::OP_ACCEL, svr_pkg::OP_DECEL: begin
            res_velocity <= cur_vel;
            if (!latch) begin
              tgt_vel <= vin;
              if (op == svr_pkg::OP_ACCEL) begin
                accel_dur <= dreq; mode <= svr_pkg::M_ACCEL; res_mode <= svr_pkg::M_ACCEL;
                res_changed <= (mode != svr_pkg::M_ACCEL);
              end else begin
                decel_dur <= dreq; mode <= svr_pkg::M_DECEL; res_mode <= svr_pkg::M_DECEL;
                res_changed <= (mode != svr_pkg::M_DECEL);
              end
              origin_vel <= cur_vel;
              elapsed <= '0;
            end else begin
              res_mode <= mode;
            end
          end
          svr_pkg::OP_ESTOP: begin
            mode <= svr_pkg::M_IDLE; res_mode <= svr_pkg::M_IDLE;
            cur_vel <= '0; tgt_vel <= '0; res_velocity <= '0;
            latch <= 1'b1; elapsed <= '0;
            res_changed <= (mode != svr_pkg::M_IDLE);
          end
          svr_pkg::OP_RESET: begin
            cur_vel <= vin; tgt_vel <= vin; res_velocity <= vin;
            origin_vel <= '0; accel_dur <= DefDur; decel_dur <= DefDur;
            elapsed <= '0; mode <= svr_pkg::M_IDLE; res_mode <= svr_pkg::M_IDLE;
            latch <= 1'b0;
          end
          default: begin
            res_velocity <= cur_vel; res_mode <= mode;
          end
        endcase
      end
    end
  end

  // latch value reported after the command
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      if (op == svr_pkg::OP_ESTOP) res_latch <= 1'b1;
      else if (op == svr_pkg::OP_RESET) res_latch <= 1'b0;
      else res_latch <= latch;
    end
  end

  // progress: quotient, or 1.0 for a zero duration
  always_comb begin
    if (total == '0) t = EaseOne;
    else t = EW'(rem_q);
  end

  assert property (@(posedge clk) disable iff (rst) cmd.mul_ez |=> ez <= EaseOne)
    else $error("ease above one");
  assert property (@(posedge clk) disable iff (rst)
    (cmd.div_step && cnt != CW'(DW + 1) && total != '0) |=> rem < {1'b0, total})
    else $error("divide remainder out of range");
  assert property (@(posedge clk) disable iff (rst)
    cmd.finish && op == svr_pkg::OP_ESTOP |=> latch && mode == svr_pkg::M_IDLE)
    else $error("emergency stop not latched");

endmodule

FILE: sv/smootherstep_velocity_ramp.sv
// flow: a non-ramp command goes load, decode, finish; a ramp tick adds the bit-serial
//   progress divide and the t2, t3, inner, ease and delta multiply steps before finish
// throughput: one transaction at a time; next input accepted once the controller is back in
//   idle, as the result is registered; a pending result stalls only the last step
// reset: synchronous active-high rst; idle mode, zero velocities, 500000 us durations,
//   min_duration_us 1000, stop latch clear
module smootherstep_velocity_ramp #(
  parameter int VelocityFracBits = svr_pkg::VelocityFracBits,
  parameter int EaseFracBits = svr_pkg::EaseFracBits,
  parameter int TimeBits = svr_pkg::TimeBits
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [svr_pkg::DurBits-1:0]   cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    opcode,
  input  logic signed [31:0]            target_velocity,
  input  logic [svr_pkg::DurBits-1:0]   ramp_duration_us,
  input  logic [svr_pkg::TickBits-1:0]  tick_us,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [31:0]            velocity,
  output logic [1:0]                    mode,
  output logic                          mode_changed,
  output logic [1:0]                    previous_mode,
  output logic                          stopped_latched
);

  svr_pkg::svr_cmd_t cmd;
  svr_pkg::svr_sts_t sts;
  logic idle;
  logic [svr_pkg::DurBits-1:0] min_dur;

  // configuration register
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) min_dur <= svr_pkg::MinDurationReset;
    else if (cfg_valid) min_dur <= cfg_data;
  end

  assign in_ready = idle;

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.finish) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  svr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_valid && in_ready),
    .out_busy(out_valid && !out_ready), .sts(sts), .cmd(cmd), .idle(idle)
  );

  svr_datapath #(
    .VelocityFracBits(VelocityFracBits), .EaseFracBits(EaseFracBits), .TimeBits(TimeBits)
  ) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts), .min_duration_us(min_dur),
    .opcode(opcode), .target_velocity(target_velocity),
    .ramp_duration_us(ramp_duration_us), .tick_us(tick_us),
    .res_velocity(velocity), .res_mode(mode), .res_changed(mode_changed),
    .res_prev(previous_mode), .res_latch(stopped_latched)
  );

endmodule

FILE: tb/sv/testbench.sv
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [23:0] TimeMask = 24'hFFFFFF;
  localparam longint EaseOne = 64'd1 << svr_pkg::EaseFracBits;
  localparam int CycleLimit = 2000000;

  typedef struct packed {
    logic signed [31:0] vel;
    logic [1:0]         md;
    logic               chg;
    logic [1:0]         prev;
    logic               latch;
  } ramp_result_t;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] tv;
    logic [23:0] dur;
    logic [15:0] tk;
    bit          typed;
    ramp_result_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [23:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] opcode = '0;
  logic signed [31:0] target_velocity = '0;
  logic [23:0] ramp_duration_us = '0;
  logic [15:0] tick_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] velocity;
  logic [1:0] mode;
  logic mode_changed;
  logic [1:0] previous_mode;
  logic stopped_latched;

  smootherstep_velocity_ramp dut (.*);

  always #6 clk = ~clk;

  // shadow ramp state
  logic signed [31:0] p_cur, p_tgt, p_start;
  logic [23:0] p_adur, p_ddur, p_elapsed, p_min;
  logic [1:0] p_mode;
  logic p_latch;

  ramp_result_t want_q[$];
  ramp_result_t typed_q[$];
  bit typed_flag_q[$];
  int errors = 0;
  int cycles = 0;
  bit quiet_out = 0;
  bit quiet_in = 0;

  function automatic bit is_near_zero(longint v);
    longint unsigned mag;
    mag = v < 0 ? -v : v;
    return mag * 64'd1000000 < (64'd1 << svr_pkg::VelocityFracBits);
  endfunction

  function automatic longint unsigned ease_curve(longint unsigned e, longint unsigned d);
    longint unsigned t, t2, t3, inner, ez;
    if (d == 0) t = EaseOne;
    else t = ((e < d ? e : d) << svr_pkg::EaseFracBits) / d;
    t2 = (t * t) >> svr_pkg::EaseFracBits;
    t3 = (t2 * t) >> svr_pkg::EaseFracBits;
    inner = 6 * t2 + 10 * EaseOne - 15 * t;
    ez = (t3 * inner) >> svr_pkg::EaseFracBits;
    return ez > EaseOne ? EaseOne : ez;
  endfunction

  function automatic logic signed [31:0] blend(logic signed [31:0] s, logic signed [31:0] g,
                                               longint unsigned ez);
    longint diff, r;
    longint unsigned mag, q;
    diff = longint'(g) - longint'(s);
    mag = diff < 0 ? -diff : diff;
    q = (mag * ez + (EaseOne >> 1)) >> svr_pkg::EaseFracBits;
    r = diff < 0 ? longint'(s) - longint'(q) : longint'(s) + longint'(q);
    return r[31:0];
  endfunction

  task automatic ramp_reset_state();
    p_cur = 0; p_tgt = 0; p_start = 0;
    p_adur = 24'(svr_pkg::DefaultDuration); p_ddur = 24'(svr_pkg::DefaultDuration);
    p_elapsed = 0; p_mode = svr_pkg::M_IDLE; p_latch = 0; p_min = svr_pkg::MinDurationReset;
  endtask

  function automatic ramp_result_t ramp_predict(logic [2:0] op, logic signed [31:0] tv,
                                                logic [23:0] dur, logic [15:0] tk);
    ramp_result_t r;
    logic [1:0] prev, nm;
    logic chg;
    longint unsigned total, ez, sum;
    logic [23:0] d;
    prev = p_mode;
    chg = 0;
    case (op)
      svr_pkg::OP_TICK: begin
        if (p_mode == svr_pkg::M_IDLE) begin
          p_cur = p_tgt;
        end else if (p_mode == svr_pkg::M_CRUISE) begin
          if (!is_near_zero(longint'(p_cur) - longint'(p_tgt))) p_cur = p_tgt;
        end else begin
          total = p_mode == svr_pkg::M_ACCEL ? p_adur : p_ddur;
          sum = longint'(p_elapsed) + tk;
          p_elapsed = sum > TimeMask ? TimeMask : sum[23:0];
          ez = ease_curve(p_elapsed, total);
          p_cur = blend(p_start, p_tgt, ez);
          if (total == 0 || p_elapsed >= total) begin
            p_mode = is_near_zero(p_tgt) ? svr_pkg::M_IDLE : svr_pkg::M_CRUISE;
            p_cur = p_tgt;
          end
        end
      end
      svr_pkg::OP_ACCEL, svr_pkg::OP_DECEL: begin
        if (!p_latch) begin
          nm = op == svr_pkg::OP_ACCEL ? svr_pkg::M_ACCEL : svr_pkg::M_DECEL;
          d = dur > p_min ? dur : p_min;
          p_tgt = tv;
          if (nm == svr_pkg::M_ACCEL) p_adur = d;
          else p_ddur = d;
          p_start = p_cur;
          p_elapsed = 0;
          p_mode = nm;
          chg = prev != nm;
        end
      end
      svr_pkg::OP_ESTOP: begin
        p_mode = svr_pkg::M_IDLE; p_cur = 0; p_tgt = 0; p_latch = 1; p_elapsed = 0;
        chg = prev != svr_pkg::M_IDLE;
      end
      svr_pkg::OP_RESET: begin
        p_cur = tv; p_tgt = tv; p_start = 0;
        p_adur = 24'(svr_pkg::DefaultDuration); p_ddur = 24'(svr_pkg::DefaultDuration);
        p_elapsed = 0; p_mode = svr_pkg::M_IDLE; p_latch = 0;
      end
      default: ;
    endcase
    r.vel = p_cur; r.md = p_mode; r.chg = chg; r.prev = prev; r.latch = p_latch;
    return r;
  endfunction

  // drive one command transaction and queue its expectation
  task automatic send_cmd(logic [2:0] op, logic [31:0] tv, logic [23:0] dur,
                          logic [15:0] tk, bit typed, ramp_result_t tw);
    ramp_result_t w;
    while (!quiet_in && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    w = ramp_predict(op, tv, dur, tk);
    want_q.push_back(w);
    typed_q.push_back(tw);
    typed_flag_q.push_back(typed);
    opcode <= op; target_velocity <= tv; ramp_duration_us <= dur; tick_us <= tk;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic write_min(logic [23:0] v);
    drain();
    cfg_data <= v;
    cfg_valid <= 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    p_min = v;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // result checking against the oldest expectation
  always @(posedge clk) begin
    ramp_result_t got, w, tw;
    bit tf;
    if (!rst && out_valid && out_ready) begin
      got = '{velocity, mode, mode_changed, previous_mode, stopped_latched};
      if (want_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
      end else begin
        w = want_q.pop_front();
        tw = typed_q.pop_front();
        tf = typed_flag_q.pop_front();
        if (tf && tw != w) begin
          errors++;
          if (errors <= 10) $display("table row disagrees: table %p predicted %p", tw, w);
        end
        if (got != w) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p actual %p", w, got);
        end
      end
    end
  end

  // receiver stalls
  always @(negedge clk)
    out_ready <= quiet_out ? 1'b1 : ($urandom_range(99) >= 23);

  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("smootherstep_velocity_ramp verification failed");
      $finish;
    end
  end

  function automatic logic [31:0] rand_vel();
    case ($urandom_range(4))
      0: return $urandom;
      1: return 32'sd0;
      2: return $urandom_range(40) - 20;
      default: return {{8{1'b0}}, 24'($urandom)} * ($urandom_range(1) ? 1 : -1);
    endcase
  endfunction

  function automatic logic [23:0] rand_dur();
    case ($urandom_range(5))
      0: return 24'($urandom);
      1: return 24'd0;
      default: return 24'($urandom_range(20000));
    endcase
  endfunction

  function automatic logic [15:0] rand_tick();
    case ($urandom_range(4))
      0: return 16'($urandom);
      1: return 16'd0;
      default: return 16'($urandom_range(3000));
    endcase
  endfunction

  stim_row_t rows[$];
  ramp_result_t none;

  initial begin
    int k, n, t, phase;
    none = '0;
    phase = 0;
    ramp_reset_state();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    // directed table
    rows.push_back('{svr_pkg::OP_TICK, 32'h0, 24'h0, 16'h0, 1,
                     '{32'sd0, svr_pkg::M_IDLE, 0, svr_pkg::M_IDLE, 0}});
    rows.push_back('{3'd5, 32'hFFFF_FFFF, 24'hFFFFFF, 16'hFFFF, 1,
                     '{32'sd0, svr_pkg::M_IDLE, 0, svr_pkg::M_IDLE, 0}});
    rows.push_back('{svr_pkg::OP_ACCEL, 32'h7FFF_FFFF, 24'h0, 16'h0, 1,
                     '{32'sd0, svr_pkg::M_ACCEL, 1, svr_pkg::M_IDLE, 0}});
    rows.push_back('{svr_pkg::OP_TICK, 32'h0, 24'h0, 16'd300, 0, none});
    rows.push_back('{svr_pkg::OP_TICK, 32'h0, 24'h0, 16'd300, 0, none});
    rows.push_back('{svr_pkg::OP_TICK, 32'h0, 24'h0, 16'hFFFF, 1,
                     '{32'sh7FFF_FFFF, svr_pkg::M_CRUISE, 0, svr_pkg::M_ACCEL, 0}});
    rows.push_back('{svr_pkg::OP_TICK, 32'h0, 24'h0, 16'h0, 0, none});
    rows.push_back('{svr_pkg::OP_DECEL, 32'h8000_0000, 24'hFFFFFF, 16'h0, 1,
                     '{32'sh7FFF_FFFF, svr_pkg::M_DECEL, 1, svr_pkg::M_CRUISE, 0}});
    rows.push_back('{svr_pkg::OP_TICK, 32'h0, 24'h0, 16'hFFFF, 0, none});
    rows.push_back('{svr_pkg::OP_DECEL, 32'h0, 24'd5000, 16'h0, 0, none});
    rows.push_back('{svr_pkg::OP_TICK, 32'h0, 24'h0, 16'd2500, 0, none});
    rows.push_back('{svr_pkg::OP_TICK, 32'h0, 24'h0, 16'd2500, 0, none});
    rows.push_back('{3'd7, 32'h0, 24'h0, 16'h0, 0, none});
    rows.push_back('{svr_pkg::OP_ACCEL, 32'h0001_0000, 24'd2000, 16'h0, 0, none});
    rows.push_back('{svr_pkg::OP_ESTOP, 32'h0, 24'h0, 16'h0, 1,
                     '{32'sd0, svr_pkg::M_IDLE, 1, svr_pkg::M_ACCEL, 1}});
    rows.push_back('{svr_pkg::OP_ACCEL, 32'h1234_5678, 24'd10, 16'h0, 1,
                     '{32'sd0, svr_pkg::M_IDLE, 0, svr_pkg::M_IDLE, 1}});
    rows.push_back('{svr_pkg::OP_ESTOP, 32'h0, 24'h0, 16'h0, 1,
                     '{32'sd0, svr_pkg::M_IDLE, 0, svr_pkg::M_IDLE, 1}});
    rows.push_back('{svr_pkg::OP_RESET, 32'h8000_0000, 24'h0, 16'h0, 1,
                     '{32'sh8000_0000, svr_pkg::M_IDLE, 0, svr_pkg::M_IDLE, 0}});
    rows.push_back('{svr_pkg::OP_RESET, 32'h0000_0001, 24'h0, 16'h0, 1,
                     '{32'sd1, svr_pkg::M_IDLE, 0, svr_pkg::M_IDLE, 0}});
    rows.push_back('{svr_pkg::OP_ACCEL, 32'h0, 24'd100, 16'h0, 0, none});
    rows.push_back('{svr_pkg::OP_TICK, 32'h0, 24'h0, 16'd1000, 0, none});
    rows.push_back('{3'd6, 32'h0, 24'h0, 16'h0, 0, none});
    foreach (rows[i]) send_cmd(rows[i].op, rows[i].tv, rows[i].dur, rows[i].tk,
                               rows[i].typed, rows[i].want);
    // register extremes, including zero durations and saturated elapsed time
    write_min(24'd0);
    send_cmd(svr_pkg::OP_ACCEL, 32'h0100_0000, 24'd0, 16'd0, 1'b0, none);
    send_cmd(svr_pkg::OP_TICK, 32'd0, 24'd0, 16'd0, 1'b0, none);
    write_min(24'hFFFFFF);
    send_cmd(svr_pkg::OP_DECEL, 32'h0, 24'd5, 16'd0, 1'b0, none);
    for (k = 0; k < 260; k++) send_cmd(svr_pkg::OP_TICK, 32'd0, 24'd0, 16'hFFFF, 1'b0, none);
    write_min(24'd1000);
    // random phases: mostly start followed by ticks
    for (n = 0; n < 565;) begin
      if (phase == 0 && n >= 180) begin
        phase = 1;
        write_min(24'($urandom_range(5000)));
      end
      if (phase == 1 && n >= 380) begin
        phase = 2;
        write_min(24'($urandom));
      end
      quiet_in = (n >= 260 && n < 320);
      quiet_out = quiet_in;
      t = $urandom_range(99);
      if (t < 55) begin
        send_cmd($urandom_range(1) ? svr_pkg::OP_ACCEL : svr_pkg::OP_DECEL, rand_vel(),
                 rand_dur(), 16'($urandom), 1'b0, none);
        n++;
        for (k = $urandom_range(12); k > 0; k--) begin
          send_cmd(svr_pkg::OP_TICK, $urandom, 24'($urandom), rand_tick(), 1'b0, none);
          n++;
        end
      end else if (t < 90) begin
        send_cmd(svr_pkg::OP_TICK, $urandom, 24'($urandom), rand_tick(), 1'b0, none);
        n++;
      end else if (t < 94) begin
        send_cmd(svr_pkg::OP_ESTOP, $urandom, 24'($urandom), 16'($urandom), 1'b0, none);
        n++;
      end else if (t < 98) begin
        send_cmd(svr_pkg::OP_RESET, rand_vel(), 24'($urandom), 16'($urandom), 1'b0, none);
        n++;
      end else begin
        send_cmd(3'($urandom_range(7, 5)), $urandom, 24'($urandom), 16'($urandom),
                 1'b0, none);
        n++;
      end
    end
    quiet_in = 0;
    quiet_out = 0;
    drain();
    if (errors == 0 && want_q.size() == 0) begin
      $display("smootherstep_velocity_ramp verification clean");
    end else begin
      $display("smootherstep_velocity_ramp verification failed");
    end
    $finish;
  end
endmodule
